// File: design/spq_pkg.sv
// Package for the sorted priority queue: depth, widths, word and slot types,
// operation codes, controller states and the ordering function.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  entry_score;
    logic [15:0] entry_arrival;
  } spq_in_t;

  typedef struct packed {
    logic [7:0]  out_score;
    logic [15:0] out_arrival;
    logic        rejected;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } spq_out_t;

  typedef struct packed {
    logic [7:0]  score;
    logic [15:0] arrival;
  } spq_slot_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PUT  = 4'b0100,
    S_POST = 4'b1000
  } spq_state_t;

  // true when slot a is served before slot b
  function automatic logic goes_before(input spq_slot_t a, input spq_slot_t b);
    logic res;
    if (a.score != b.score) begin
      res = a.score > b.score;
    end else begin
      res = a.arrival < b.arrival;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/spq_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 24
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [DATA_W-1:0]          wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/sorted_priority_queue.sv
// Sorted priority queue of QUEUE_DEPTH slots held in one RAM, highest score at
// slot 0, earlier arrival first on equal score. An input word is taken only when
// the controller is idle; a result may still sit in the output register then.
// Every cycle at most one slot moves through the RAM's single write port, so an
// enqueue shifts each lower-ranked entry down one slot before writing the new word
// and a dequeue shifts the rest up one slot. A new word is taken only after the
// finished word is loaded into the output register, waiting while that is held.
// No clearing pass after reset. Depends on spq_pkg and spq_ram.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire spq_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output spq_out_t      out_data
);

  spq_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              op_r, op_nxt;
  spq_slot_t         new_r, new_nxt;
  spq_slot_t         pend_r, pend_nxt;
  logic              pend_rej_r, pend_rej_nxt;
  logic              out_valid_r, out_valid_nxt;
  spq_out_t          out_r, out_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  spq_slot_t         ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  spq_slot_t         ram_rdata;

  logic              cnt_full;
  logic              cnt_zero;
  logic              scan_last;
  spq_slot_t         in_slot;

  spq_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W ($bits(spq_slot_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign cnt_zero  = cnt_r == '0;
  assign scan_last = CNT_W'(idx_r) == cnt_r - 1'b1;
  assign in_slot   = '{score: in_data.entry_score, arrival: in_data.entry_arrival};

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    new_nxt       = new_r;
    pend_nxt      = pend_r;
    pend_rej_nxt  = pend_rej_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = new_r;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        ram_raddr = (in_data.operation == OP_ENQ) ? IDX_W'(cnt_r - 1'b1) : '0;
        if (in_valid) begin
          op_nxt       = in_data.operation;
          new_nxt      = in_slot;
          pend_nxt     = '0;
          pend_rej_nxt = 1'b0;
          if (in_data.operation == OP_ENQ) begin
            if (cnt_full) begin
              pend_rej_nxt = 1'b1;
              state_nxt    = S_POST;
            end else if (cnt_zero) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_slot;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_POST;
            end else begin
              idx_nxt   = IDX_W'(cnt_r - 1'b1);
              state_nxt = S_SCAN;
            end
          end else begin
            if (cnt_zero) begin
              pend_rej_nxt = 1'b1;
              state_nxt    = S_POST;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (op_r == OP_ENQ) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r + 1'b1;
          if (goes_before(new_r, ram_rdata)) begin
            ram_wdata = ram_rdata;
            if (idx_r == '0) begin
              state_nxt = S_PUT;
            end else begin
              ram_raddr = idx_r - 1'b1;
              idx_nxt   = idx_r - 1'b1;
            end
          end else begin
            ram_wdata = new_r;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_POST;
          end
        end else begin
          if (idx_r == '0) begin
            pend_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = idx_r - 1'b1;
            ram_wdata = ram_rdata;
          end
          if (scan_last) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_POST;
          end else begin
            ram_raddr = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.out_score   = pend_r.score;
          out_nxt.out_arrival = pend_r.arrival;
          out_nxt.rejected    = pend_rej_r;
          out_nxt.entry_count = 5'(cnt_r);
          out_nxt.is_empty    = cnt_zero;
          out_nxt.is_full     = cnt_full;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    new_r      <= new_nxt;
    pend_r     <= pend_nxt;
    pend_rej_r <= pend_rej_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTHESIS
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input stays open after accepting a word");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CNT_W'(idx_r) < cnt_r)
    else $error("scan index outside live entries");

  a_post_writes_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POST && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("finished word not loaded into output register");
`endif

endmodule

`default_nettype wire
